/* rtl/rau_pkg.sv */
// Shared types and constants for the rational arithmetic unit.
// No dependencies; imported by every other module of the block.
`timescale 1ns / 1ps
package rau_pkg;

   localparam int WIDTH   = 32;                 // committed accumulator width
   localparam int OPW     = WIDTH + 1;          // conditioned operand width
   localparam int PW      = 2 * OPW;            // product / sum width
   localparam int DW      = 64;                 // GCD and divider width
   localparam int CNTW    = 7;
   localparam int KW      = 6;

   localparam logic [2:0] ACT_LOAD = 3'd0;
   localparam logic [2:0] ACT_ADD  = 3'd1;
   localparam logic [2:0] ACT_SUB  = 3'd2;
   localparam logic [2:0] ACT_MUL  = 3'd3;
   localparam logic [2:0] ACT_DIV  = 3'd4;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_ZERO_DEN = 2'd1;
   localparam logic [1:0] STAT_OVERFLOW = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_GCD,
      ST_DIV,
      ST_CHECK,
      ST_WINIT,
      ST_WHOLE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic mul;
      logic sum;
      logic gcd_step;
      logic div_init;
      logic div_step;
      logic commit;
      logic whole_init;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic req_skip;
      logic gcd_done;
      logic div_last;
      logic out_free;
   } sts_type;

endpackage

/* rtl/rau_ctrl.sv */
// Sequencer for the rational arithmetic unit.
// Depends on rau_pkg; drives the datapath through cmd_type, watches sts_type.
`timescale 1ns / 1ps
module rau_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output rau_pkg::cmd_type cmd,
   input  rau_pkg::sts_type sts
);
   import rau_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = sts.req_skip ? ST_WINIT : ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_GCD;
         end
         ST_GCD: begin
            if (sts.gcd_done) begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.commit = 1'b1;
            state_in   = ST_WINIT;
         end
         ST_WINIT: begin
            cmd.whole_init = 1'b1;
            state_in       = ST_WHOLE;
         end
         ST_WHOLE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/rau_datapath.sv */
// Datapath: accumulator, multipliers, binary GCD, shared restoring divider
// and result register. Depends on rau_pkg; controlled by rau_ctrl.
`timescale 1ns / 1ps
module rau_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  rau_pkg::cmd_type          cmd,
   output rau_pkg::sts_type          sts,
   input  logic [2:0]                in_action,
   input  logic signed [31:0]        in_num,
   input  logic signed [31:0]        in_den,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic signed [31:0]        out_num,
   output logic [30:0]               out_den,
   output logic signed [31:0]        out_whole,
   output logic [1:0]                out_status
);
   import rau_pkg::*;

   localparam logic [DW-1:0] LIM = DW'(1) << (WIDTH - 1);

   logic signed [WIDTH-1:0] acc_num_ff;
   logic [WIDTH-1:0]        acc_den_ff;
   logic [2:0]              act_ff;
   logic signed [OPW-1:0]   c_ff, d_ff;
   logic [1:0]              stat_ff;
   logic signed [PW-1:0]    pa_ff, pb_ff, pm_ff;
   logic                    neg_ff;
   logic [DW-1:0]           nmag_ff, m_ff, u_ff, v_ff;
   logic [KW-1:0]           k_ff;
   logic [DW-1:0]           q1_ff, q2_ff, r1_ff, r2_ff, dvs_ff;
   logic [CNTW-1:0]         cnt_ff;
   logic                    wneg_ff;
   logic                    rsp_valid_ff;
   logic signed [31:0]      out_num_ff, out_whole_ff;
   logic [30:0]             out_den_ff;
   logic [1:0]              out_status_ff;

   // capture
   logic                    nop, zero_den;
   logic signed [OPW-1:0]   cs, ds, cx, dx;
   always_comb begin
      nop      = in_action > ACT_DIV;
      zero_den = (in_den == '0) || ((in_action == ACT_DIV) && (in_num == '0));
      cs = OPW'(in_num);
      ds = OPW'(in_den);
      if (in_action == ACT_DIV) begin
         cx = ds;
         dx = cs;
      end else begin
         cx = cs;
         dx = ds;
      end
      if (dx < 0) begin
         cx = -cx;
         dx = -dx;
      end
   end

   // products and sum
   logic signed [OPW-1:0] a_ext, b_ext, sel;
   logic signed [PW-1:0]  n_sum, m_sum, n_mag;
   always_comb begin
      a_ext = OPW'(acc_num_ff);
      b_ext = $signed({1'b0, acc_den_ff});
      sel   = (act_ff == ACT_MUL || act_ff == ACT_DIV) ? c_ff : d_ff;
      case (act_ff)
         ACT_ADD:  n_sum = pa_ff + pb_ff;
         ACT_SUB:  n_sum = pa_ff - pb_ff;
         ACT_LOAD: n_sum = PW'(c_ff);
         default:  n_sum = pa_ff;
      endcase
      m_sum = (act_ff == ACT_LOAD) ? PW'(d_ff) : pm_ff;
      n_mag = (n_sum < 0) ? -n_sum : n_sum;
   end

   // divider step
   logic [DW:0] rs1, rs2;
   logic        ge1, ge2;
   always_comb begin
      rs1 = {r1_ff, q1_ff[DW-1]};
      rs2 = {r2_ff, q2_ff[DW-1]};
      ge1 = rs1 >= {1'b0, dvs_ff};
      ge2 = rs2 >= {1'b0, dvs_ff};
   end

   // overflow check
   logic ovf;
   always_comb begin
      ovf = neg_ff ? (q1_ff > LIM) : (q1_ff > LIM - DW'(1));
      if (q2_ff > LIM - DW'(1)) begin
         ovf = 1'b1;
      end
   end

   logic [WIDTH-1:0] acc_mag;
   assign acc_mag = acc_num_ff[WIDTH-1] ? WIDTH'(-acc_num_ff) : acc_num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_num_ff   <= '0;
         acc_den_ff   <= WIDTH'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit && !ovf) begin
            acc_num_ff <= neg_ff ? WIDTH'(-q1_ff[WIDTH-1:0]) : q1_ff[WIDTH-1:0];
            acc_den_ff <= q2_ff[WIDTH-1:0];
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff  <= in_action;
         c_ff    <= cx;
         d_ff    <= dx;
         stat_ff <= (!nop && zero_den) ? STAT_ZERO_DEN : STAT_OK;
      end
      if (cmd.mul) begin
         pa_ff <= PW'(a_ext * sel);
         pb_ff <= PW'(c_ff * b_ext);
         pm_ff <= PW'(b_ext * d_ff);
      end
      if (cmd.sum) begin
         neg_ff  <= n_sum < 0;
         nmag_ff <= n_mag[DW-1:0];
         m_ff    <= m_sum[DW-1:0];
         u_ff    <= n_mag[DW-1:0];
         v_ff    <= m_sum[DW-1:0];
         k_ff    <= '0;
      end
      if (cmd.gcd_step) begin
         if (!u_ff[0] && !v_ff[0]) begin
            u_ff <= u_ff >> 1;
            v_ff <= v_ff >> 1;
            k_ff <= k_ff + KW'(1);
         end else if (!u_ff[0]) begin
            u_ff <= u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_ff <= v_ff >> 1;
         end else if (u_ff >= v_ff) begin
            u_ff <= (u_ff - v_ff) >> 1;
         end else begin
            u_ff <= (v_ff - u_ff) >> 1;
            v_ff <= u_ff;
         end
      end
      if (cmd.div_init) begin
         q1_ff  <= nmag_ff;
         q2_ff  <= m_ff;
         r1_ff  <= '0;
         r2_ff  <= '0;
         dvs_ff <= v_ff << k_ff;
         cnt_ff <= CNTW'(DW);
      end
      if (cmd.whole_init) begin
         q1_ff   <= {acc_mag, {(DW - WIDTH){1'b0}}};
         q2_ff   <= '0;
         r1_ff   <= '0;
         r2_ff   <= '0;
         dvs_ff  <= DW'(acc_den_ff);
         cnt_ff  <= CNTW'(WIDTH);
         wneg_ff <= acc_num_ff[WIDTH-1];
      end
      if (cmd.div_step) begin
         q1_ff  <= {q1_ff[DW-2:0], ge1};
         q2_ff  <= {q2_ff[DW-2:0], ge2};
         r1_ff  <= ge1 ? DW'(rs1 - {1'b0, dvs_ff}) : rs1[DW-1:0];
         r2_ff  <= ge2 ? DW'(rs2 - {1'b0, dvs_ff}) : rs2[DW-1:0];
         cnt_ff <= cnt_ff - CNTW'(1);
      end
      if (cmd.commit) begin
         stat_ff <= ovf ? STAT_OVERFLOW : STAT_OK;
      end
      if (cmd.out_load) begin
         out_num_ff    <= acc_num_ff;
         out_den_ff    <= acc_den_ff[30:0];
         out_whole_ff  <= wneg_ff ? -q1_ff[31:0] : q1_ff[31:0];
         out_status_ff <= stat_ff;
      end
   end

   always_comb begin
      sts          = '0;
      sts.req_skip = nop || zero_den;
      sts.gcd_done = u_ff == '0;
      sts.div_last = cnt_ff == CNTW'(1);
      sts.out_free = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign out_num    = out_num_ff;
   assign out_den    = out_den_ff;
   assign out_whole  = out_whole_ff;
   assign out_status = out_status_ff;

endmodule

/* rtl/rational_arith_unit_top.sv */
// Rational arithmetic unit: top level, request and response stream ports.
// Depends on rau_pkg, rau_ctrl and rau_datapath.
`timescale 1ns / 1ps
// Holds a fraction in lowest terms with a positive denominator and applies
// load, add, subtract, multiply or divide by each request's operand, then
// reduces with a binary GCD (one shift or subtract-and-shift per cycle) and
// divides out the GCD on a 1-bit-per-cycle restoring divider, then forms
// the whole part on the same divider. A no-op or zero-denominator request
// skips straight to forming the whole part. One request is in flight at a
// time; the response sits in an output register so the next request is
// taken while it waits.
module rational_arith_unit_top (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // [2:0] action, [34:3] operand_num, [66:35] operand_den, [71:67] zero
   input  logic [71:0]   req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [31:0] result_num, [62:32] result_den, [94:63] whole_part,
   // [96:95] status, [103:97] zero
   output logic [103:0]  rsp_tdata
);
   import rau_pkg::*;

   cmd_type            cmd;
   sts_type            sts;
   logic signed [31:0] out_num, out_whole;
   logic [30:0]        out_den;
   logic [1:0]         out_status;

   rau_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   rau_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .in_action  (req_tdata[2:0]),
      .in_num     (req_tdata[34:3]),
      .in_den     (req_tdata[66:35]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .out_num    (out_num),
      .out_den    (out_den),
      .out_whole  (out_whole),
      .out_status (out_status)
   );

   assign rsp_tdata = {7'b0, out_status, out_whole, out_den, out_num};

endmodule

/* tb/sv/rational_arith_unit_top_test.sv */
// Testbench for rational_arith_unit_top: directed table then random requests,
// checked by a local rational predictor or typed table rows. Depends on rau_pkg.
`timescale 1ns / 1ps
module rational_arith_unit_top_test;
   import rau_pkg::*;

   localparam logic [2:0] ACT_NOP = 3'd7;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] whole;
      logic [30:0] den;
      logic [31:0] num;
   } frac_rsp_type;

   typedef struct {
      logic [2:0]   act;
      int           num;
      int           den;
      bit           typed;
      frac_rsp_type rsp;
   } vec_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [71:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;

   longint       acc_n = 0;
   longint       acc_d = 1;
   frac_rsp_type pending_rsp[$];
   int           errors = 0;
   bit           stim_done = 1'b0;

   rational_arith_unit_top u_top (.*);

   always #2 clock = ~clock;

   function automatic frac_rsp_type rational_step(input logic [2:0] act, input int cn,
                                                  input int cd);
      longint a, b, c, d, n, m, t, lim;
      longint unsigned un, g, x, y, r;
      frac_rsp_type o;
      logic [1:0] st;
      lim = 64'sd1 <<< 31;
      a = acc_n; b = acc_d; c = cn; d = cd;
      st = STAT_OK;
      if (act > ACT_DIV) begin
         st = STAT_OK;
      end else if (d == 0 || (act == ACT_DIV && c == 0)) begin
         st = STAT_ZERO_DEN;
      end else begin
         if (act == ACT_DIV) begin
            t = c; c = d; d = t;
         end
         if (d < 0) begin
            c = -c; d = -d;
         end
         case (act)
            ACT_LOAD: begin n = c; m = d; end
            ACT_ADD:  begin n = a * d + c * b; m = b * d; end
            ACT_SUB:  begin n = a * d - c * b; m = b * d; end
            default:  begin n = a * c; m = b * d; end
         endcase
         un = (n < 0) ? longint'(-n) : longint'(n);
         x = un; y = m;
         while (y != 0) begin
            r = x % y; x = y; y = r;
         end
         g = x;
         un = un / g;
         m = longint'(longint'(m) / longint'(g));
         if ((n < 0 && un > lim) || (n >= 0 && un > lim - 1) || m > lim - 1) begin
            st = STAT_OVERFLOW;
         end else begin
            acc_n = (n < 0) ? -longint'(un) : longint'(un);
            acc_d = m;
         end
      end
      o.num = acc_n[31:0];
      o.den = acc_d[30:0];
      o.whole = 32'(acc_n / acc_d);
      o.status = st;
      return o;
   endfunction

   task automatic send_req(input logic [2:0] act, input int num, input int den,
                           input bit typed, input frac_rsp_type typed_rsp);
      frac_rsp_type p;
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, den, num, act};
      do @(posedge clock); while (!req_tready);
      p = rational_step(act, num, den);
      pending_rsp.push_back(typed ? typed_rsp : p);
      @(negedge clock);
   endtask

   task automatic idle_gap(input int n);
      req_tvalid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // response checker
   always @(posedge clock) begin
      frac_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[96:0];
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response %h", $time, got);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (got.num !== want.num) begin
               $display("%0t: result_num exp %0d got %0d", $time,
                        $signed(want.num), $signed(got.num));
               errors++;
            end
            if (got.den !== want.den) begin
               $display("%0t: result_den exp %0d got %0d", $time, want.den, got.den);
               errors++;
            end
            if (got.whole !== want.whole) begin
               $display("%0t: whole_part exp %0d got %0d", $time,
                        $signed(want.whole), $signed(got.whole));
               errors++;
            end
            if (got.status !== want.status) begin
               $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
               errors++;
            end
         end
      end
   end

   // receiver stall pattern, changing mode periodically
   initial begin
      int mode;
      mode = 0;
      forever begin
         @(negedge clock);
         if ($time % 256 == 0) mode = $urandom_range(0, 3);
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 9) < 7);
            2: rsp_tready <= ($urandom_range(0, 99) < 5);
            default: rsp_tready <= (($time / 20) % 3 != 0);
         endcase
      end
   end

   initial begin
      #4ms;
      $display("** rational_arith_unit_top: FAILED **");
      $finish;
   end

   initial begin
      vec_type tbl[$];
      frac_rsp_type z;
      logic [2:0] act;
      int num, den, burst, k;
      z = '0;
      tbl = '{
         '{ACT_NOP,  0, 0, 1, '{STAT_OK, 32'd0, 31'd1, 32'd0}},
         '{ACT_LOAD, 5, 0, 1, '{STAT_ZERO_DEN, 32'd0, 31'd1, 32'd0}},
         '{ACT_LOAD, 7, -2, 1, '{STAT_OK, -32'sd3, 31'd2, -32'sd7}},
         '{3'd5,     1, 1, 1, '{STAT_OK, -32'sd3, 31'd2, -32'sd7}},
         '{ACT_DIV,  0, 5, 1, '{STAT_ZERO_DEN, -32'sd3, 31'd2, -32'sd7}},
         '{ACT_ADD,  3, 4, 0, z},
         '{ACT_SUB,  -5, 6, 0, z},
         '{ACT_MUL,  4, -9, 0, z},
         '{ACT_DIV,  -3, 7, 0, z},
         '{3'd6,     9, 9, 0, z},
         '{ACT_LOAD, 0, -7, 1, '{STAT_OK, 32'd0, 31'd1, 32'd0}},
         '{ACT_LOAD, 32'h7fffffff, 1, 1,
           '{STAT_OK, 32'h7fffffff, 31'd1, 32'h7fffffff}},
         '{ACT_ADD,  1, 1, 1, '{STAT_OVERFLOW, 32'h7fffffff, 31'd1, 32'h7fffffff}},
         '{ACT_MUL,  32'h7fffffff, 32'h7fffffff, 0, z},
         '{ACT_LOAD, 32'h80000000, 1, 1,
           '{STAT_OK, 32'h80000000, 31'd1, 32'h80000000}},
         '{ACT_SUB,  1, 1, 0, z},
         '{ACT_MUL,  -1, 1, 0, z},
         '{ACT_LOAD, 1, 32'h80000000, 1,
           '{STAT_OVERFLOW, 32'h80000000, 31'd1, 32'h80000000}},
         '{ACT_LOAD, 32'h80000000, 32'h80000000, 0, z},
         '{ACT_LOAD, 1, 32'h7fffffff, 0, z},
         '{ACT_DIV,  32'h80000000, 32'h7fffffff, 0, z},
         '{ACT_ADD,  32'h7fffffff, 32'h7ffffffe, 0, z},
         '{ACT_DIV,  32'h80000000, 32'h80000000, 0, z},
         '{ACT_LOAD, 1, -1, 0, z},
         '{ACT_SUB,  -1, -1, 0, z}
      };
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (tbl[i]) begin
         send_req(tbl[i].act, tbl[i].num, tbl[i].den, tbl[i].typed, tbl[i].rsp);
         if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 30));
      end
      k = 0;
      while (k < 500) begin
         burst = $urandom_range(1, 20);
         repeat (burst) begin
            k++;
            if (k == 250) begin
               req_tvalid <= 1'b0;
               while (pending_rsp.size() != 0) @(negedge clock);
            end
            case ($urandom_range(0, 19))
               0: act = 3'($urandom_range(5, 7));
               1, 2: act = ACT_LOAD;
               default: act = 3'($urandom_range(1, 4));
            endcase
            if ($urandom_range(0, 9) < 2) begin
               num = $urandom;
               den = $urandom;
            end else begin
               num = int'($urandom_range(0, 64)) - 32;
               den = int'($urandom_range(0, 40)) - 20;
            end
            if ($urandom_range(0, 29) == 0) den = 0;
            if ($urandom_range(0, 29) == 0) num = 0;
            send_req(act, num, den, 1'b0, z);
         end
         if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 400));
      end
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("** rational_arith_unit_top: PASSED **");
      end else begin
         $display("** rational_arith_unit_top: FAILED **");
      end
      $finish;
   end
endmodule
